/* hw/rtl/dksb_pkg.sv */
// Shared types and constants for the destination-keyed send buffer.
// No dependencies; every other file in hw/rtl imports this package.
package dksb_pkg;

  localparam int HANDLE_BITS = 16;
  localparam int ADDR_BITS   = 32;
  localparam int KIND_BITS   = 2;
  localparam int COUNT_W     = 6;

  // operation codes
  localparam logic [KIND_BITS-1:0] KIND_PUSH = 2'd0;
  localparam logic [KIND_BITS-1:0] KIND_PULL = 2'd1;
  localparam logic [KIND_BITS-1:0] KIND_DROP = 2'd2;

  // register map
  localparam logic REG_CAPACITY = 1'b0;
  localparam logic [COUNT_W-1:0] CAP_RESET = 6'd32;

  typedef struct packed {
    logic [KIND_BITS-1:0]   kind;
    logic [ADDR_BITS-1:0]   dest_addr;
    logic [HANDLE_BITS-1:0] packet_handle;
  } in_item_t;

  typedef struct packed {
    logic                   has_packet;
    logic                   evicted;
    logic [HANDLE_BITS-1:0] out_handle;
    logic [COUNT_W-1:0]     removed_count;
    logic [COUNT_W-1:0]     occupancy;
    logic                   last;
  } out_item_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0]   addr;
    logic [HANDLE_BITS-1:0] handle;
  } entry_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PUSH_RD,
    ST_PUSH_WR,
    ST_CNT_RD,
    ST_CNT_EV,
    ST_CMP_RD,
    ST_CMP_EV,
    ST_DROP_OUT,
    ST_NOP_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic push_wr;
    logic cnt_ev;
    logic scan_rst;
    logic cmp_ev;
    logic fill_upd;
    logic drop_out;
    logic nop_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [KIND_BITS-1:0] new_kind;
    logic [KIND_BITS-1:0] op_kind;
    logic                 scan_end;
    logic                 no_match;
  } ctrl_sts_t;

endpackage

/* hw/rtl/dest_keyed_send_buffer_unit.sv */
// Destination-keyed send buffer: a bounded FIFO of packet handles tagged with
// a 32-bit destination address, kept in a circular store of DEPTH entries.
// Commands enter on start/in_item and are taken when busy is low. kind 0
// pushes (evicting and reporting the oldest word once occupancy reaches the
// capacity register, 0 read as 1 and clamped to DEPTH), kind 1 pulls every
// matching entry in FIFO order, kind 2 drops every matching entry and reports
// the count; other codes report only the occupancy. Results leave on
// out_item, each marked by a one-cycle out_valid strobe; the receiver cannot
// stall, so none is held back. A push reads the head entry, then writes the
// tail and registers its word. Pull and drop make a counting pass and then a
// compaction pass, each stepping through the stored entries (registered store
// read, then compare) before finishing: a drop reports its word after the
// compaction pass, a pull with matches emits its words during the compaction
// pass, and a pull that matches nothing skips the second pass and reports one
// word. Spare codes report one word. One item at a time.
// The capacity register (byte address 0) resets to 32; reset empties the
// buffer at once by clearing the fill count, with no sweep of the store.
// Depends on dksb_pkg, dksb_regs, dksb_ctrl and dksb_dp.
module dest_keyed_send_buffer_unit #(
  parameter int DEPTH = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  dksb_pkg::in_item_t   in_item,
  output logic                 out_valid,
  output dksb_pkg::out_item_t  out_item,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import dksb_pkg::*;

  logic [COUNT_W-1:0] cap;
  ctrl_cmd_t          cmd;
  ctrl_sts_t          sts;

  dksb_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cap     (cap)
  );

  dksb_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  dksb_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cap       (cap),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

/* hw/rtl/dksb_regs.sv */
// APB-style configuration register (capacity) for the send buffer.
// Depends on dksb_pkg.
module dksb_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [2:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  output logic [dksb_pkg::COUNT_W-1:0]   cap
);
  import dksb_pkg::*;

  logic [COUNT_W-1:0] cap_r, cap_nxt;
  logic               wr_hit;

  assign wr_hit = psel & penable & pwrite & (paddr[2] == REG_CAPACITY);

  always_comb begin
    cap_nxt = cap_r;
    if (wr_hit) begin
      cap_nxt = pwdata[COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else begin
      cap_r <= cap_nxt;
    end
  end

  assign prdata = (paddr[2] == REG_CAPACITY) ? {{(32-COUNT_W){1'b0}}, cap_r} : 32'd0;
  assign pready = 1'b1;
  assign cap    = cap_r;

endmodule

/* hw/rtl/dksb_ctrl.sv */
// Sequencer for the send buffer: push, count pass, compaction pass, reporting.
// Depends on dksb_pkg; drives dksb_dp through ctrl_cmd_t / ctrl_sts_t.
module dksb_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  dksb_pkg::ctrl_sts_t  sts,
  output dksb_pkg::ctrl_cmd_t  cmd
);
  import dksb_pkg::*;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          case (sts.new_kind)
            KIND_PUSH: state_nxt = ST_PUSH_RD;
            KIND_PULL: state_nxt = ST_CNT_RD;
            KIND_DROP: state_nxt = ST_CNT_RD;
            default:   state_nxt = ST_NOP_OUT;
          endcase
        end
      end
      ST_PUSH_RD: state_nxt = ST_PUSH_WR;
      ST_PUSH_WR: state_nxt = ST_IDLE;
      ST_CNT_RD: begin
        if (sts.scan_end) begin
          // pull with nothing to take reports an empty word
          if (sts.op_kind == KIND_PULL && sts.no_match) begin
            state_nxt = ST_NOP_OUT;
          end else begin
            state_nxt = ST_CMP_RD;
          end
        end else begin
          state_nxt = ST_CNT_EV;
        end
      end
      ST_CNT_EV: state_nxt = ST_CNT_RD;
      ST_CMP_RD: begin
        if (sts.scan_end) begin
          state_nxt = (sts.op_kind == KIND_DROP) ? ST_DROP_OUT : ST_IDLE;
        end else begin
          state_nxt = ST_CMP_EV;
        end
      end
      ST_CMP_EV:   state_nxt = ST_CMP_RD;
      ST_DROP_OUT: state_nxt = ST_IDLE;
      ST_NOP_OUT:  state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state_r)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_PUSH_RD: ;
      ST_PUSH_WR:  cmd.push_wr = 1'b1;
      ST_CNT_RD:   cmd.scan_rst = sts.scan_end;
      ST_CNT_EV:   cmd.cnt_ev = 1'b1;
      ST_CMP_RD:   cmd.fill_upd = sts.scan_end;
      ST_CMP_EV:   cmd.cmp_ev = 1'b1;
      ST_DROP_OUT: cmd.drop_out = 1'b1;
      ST_NOP_OUT:  cmd.nop_out = 1'b1;
      default:     busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* hw/rtl/dksb_dp.sv */
// Datapath: circular entry store, head/fill pointers, scan counters, result register.
// Depends on dksb_pkg; commanded by dksb_ctrl.
module dksb_dp #(
  parameter int DEPTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  dksb_pkg::in_item_t            in_item,
  input  logic [dksb_pkg::COUNT_W-1:0]  cap,
  input  dksb_pkg::ctrl_cmd_t           cmd,
  output dksb_pkg::ctrl_sts_t           sts,
  output logic                          out_valid,
  output dksb_pkg::out_item_t           out_item
);
  import dksb_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = AW + 1;
  localparam int EW = COUNT_W + 1;

  entry_t store_mem [DEPTH];

  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] wr_r, wr_nxt;
  logic [CW-1:0] match_r, match_nxt;
  logic [CW-1:0] emit_r, emit_nxt;
  in_item_t      op_r, op_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_item_t     out_item_r, out_item_nxt;
  entry_t        rd_data_r;

  logic          wr_en;
  logic [CW-1:0] wr_off;
  entry_t        wr_data;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [EW-1:0] effcap;
  logic          evict, hit;

  // logical offset from head to physical slot, wrapping at DEPTH
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] base, input logic [CW-1:0] off);
    logic [SW-1:0] s;
    s = SW'(base) + SW'(off);
    if (s >= SW'(DEPTH)) begin
      s = s - SW'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  always_comb begin
    if (cap == '0) begin
      effcap = EW'(1);
    end else if ({1'b0, cap} > EW'(DEPTH)) begin
      effcap = EW'(DEPTH);
    end else begin
      effcap = {1'b0, cap};
    end
  end

  assign evict   = EW'(fill_r) >= effcap;
  assign hit     = rd_data_r.addr == op_r.dest_addr;
  assign rd_addr = phys(head_r, idx_r);
  assign wr_addr = phys(head_r, wr_off);

  always_comb begin
    head_nxt      = head_r;
    fill_nxt      = fill_r;
    idx_nxt       = idx_r;
    wr_nxt        = wr_r;
    match_nxt     = match_r;
    emit_nxt      = emit_r;
    op_nxt        = op_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    wr_en         = 1'b0;
    wr_off        = wr_r;
    wr_data       = rd_data_r;

    if (cmd.load) begin
      op_nxt    = in_item;
      idx_nxt   = '0;
      wr_nxt    = '0;
      match_nxt = '0;
      emit_nxt  = '0;
    end

    if (cmd.push_wr) begin
      // tail slot is the same before and after dropping the head
      wr_en        = 1'b1;
      wr_off       = fill_r;
      wr_data.addr   = op_r.dest_addr;
      wr_data.handle = op_r.packet_handle;
      if (evict) begin
        head_nxt = phys(head_r, CW'(1));
      end else begin
        fill_nxt = fill_r + 1'b1;
      end
      out_valid_nxt              = 1'b1;
      out_item_nxt               = '0;
      out_item_nxt.has_packet    = evict;
      out_item_nxt.evicted       = evict;
      out_item_nxt.out_handle    = evict ? rd_data_r.handle : '0;
      out_item_nxt.occupancy     = COUNT_W'(fill_nxt);
      out_item_nxt.last          = 1'b1;
    end

    if (cmd.cnt_ev) begin
      idx_nxt = idx_r + 1'b1;
      if (hit) begin
        match_nxt = match_r + 1'b1;
      end
    end

    if (cmd.scan_rst) begin
      idx_nxt = '0;
      wr_nxt  = '0;
    end

    if (cmd.cmp_ev) begin
      idx_nxt = idx_r + 1'b1;
      if (hit) begin
        emit_nxt = emit_r + 1'b1;
        if (op_r.kind == KIND_PULL) begin
          out_valid_nxt           = 1'b1;
          out_item_nxt            = '0;
          out_item_nxt.has_packet = 1'b1;
          out_item_nxt.out_handle = rd_data_r.handle;
          out_item_nxt.occupancy  = COUNT_W'(fill_r - match_r);
          out_item_nxt.last       = (CW'(emit_r + 1'b1) == match_r);
        end
      end else begin
        wr_en  = 1'b1;
        wr_nxt = wr_r + 1'b1;
      end
    end

    if (cmd.fill_upd) begin
      fill_nxt = wr_r;
    end

    if (cmd.drop_out) begin
      out_valid_nxt              = 1'b1;
      out_item_nxt               = '0;
      out_item_nxt.removed_count = COUNT_W'(match_r);
      out_item_nxt.occupancy     = COUNT_W'(fill_r);
      out_item_nxt.last          = 1'b1;
    end

    if (cmd.nop_out) begin
      out_valid_nxt          = 1'b1;
      out_item_nxt           = '0;
      out_item_nxt.occupancy = COUNT_W'(fill_r);
      out_item_nxt.last      = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_mem[wr_addr] <= wr_data;
    end
    rd_data_r <= store_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    wr_r       <= wr_nxt;
    match_r    <= match_nxt;
    emit_r     <= emit_nxt;
    op_r       <= op_nxt;
    out_item_r <= out_item_nxt;
  end

  assign sts.new_kind = in_item.kind;
  assign sts.op_kind  = op_r.kind;
  assign sts.scan_end = (idx_r == fill_r);
  assign sts.no_match = (match_r == '0);

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

/* bench/dest_keyed_send_buffer_unit_tb.sv */
`timescale 1ns / 100ps
// Self-checking bench for dest_keyed_send_buffer_unit: push, pull, drop and spare commands
// against an in-bench queue model of the buffer, over several capacity settings.
// Depends on dksb_pkg and the RTL of dest_keyed_send_buffer_unit.
module dest_keyed_send_buffer_unit_tb;
  import dksb_pkg::*;

  localparam int DEPTH = 32;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam logic [KIND_BITS-1:0] KIND_SPARE = 2'd3;

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  in_item_t in_item;
  logic out_valid;
  out_item_t out_item;
  logic psel;
  logic penable;
  logic pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  dest_keyed_send_buffer_unit #(.DEPTH(DEPTH)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // buffer model
  entry_t held_entries[$];
  logic [COUNT_W-1:0] capacity_reg = CAP_RESET;
  out_item_t expected_words[$];

  int unsigned error_count = 0;
  int unsigned word_count = 0;
  int unsigned evict_count = 0;
  int unsigned longest_pull = 0;
  int unsigned kind_count[4] = '{0, 0, 0, 0};
  int unsigned cycle_count = 0;
  bit no_gap_run = 1'b0;
  logic [31:0] addr_pool[4];
  out_item_t want_word;

  function automatic in_item_t mk(input logic [KIND_BITS-1:0] k, input logic [31:0] a,
                                  input logic [15:0] h);
    in_item_t it;
    it.kind = k;
    it.dest_addr = a;
    it.packet_handle = h;
    return it;
  endfunction

  // works out the result words of one accepted command and updates the model
  function automatic void buffer_step(input in_item_t it);
    out_item_t w;
    entry_t e;
    entry_t kept[$];
    logic [HANDLE_BITS-1:0] taken[$];
    int unsigned eff;
    eff = (capacity_reg == 0) ? 1 : ((capacity_reg > DEPTH) ? DEPTH : capacity_reg);
    w = '0;
    w.last = 1'b1;
    kind_count[it.kind]++;
    case (it.kind)
      KIND_PUSH: begin
        if (held_entries.size() >= eff && held_entries.size() > 0) begin
          w.has_packet = 1'b1;
          w.evicted = 1'b1;
          w.out_handle = held_entries[0].handle;
          held_entries.delete(0);
          evict_count++;
        end
        if (held_entries.size() < DEPTH) begin
          e.addr = it.dest_addr;
          e.handle = it.packet_handle;
          held_entries.insert(held_entries.size(), e);
        end
        w.occupancy = COUNT_W'(held_entries.size());
        expected_words.insert(expected_words.size(), w);
      end
      KIND_PULL, KIND_DROP: begin
        foreach (held_entries[i]) begin
          if (held_entries[i].addr == it.dest_addr)
            taken.insert(taken.size(), held_entries[i].handle);
          else kept.insert(kept.size(), held_entries[i]);
        end
        held_entries = kept;
        w.occupancy = COUNT_W'(held_entries.size());
        if (it.kind == KIND_DROP) begin
          w.removed_count = COUNT_W'(taken.size());
          expected_words.insert(expected_words.size(), w);
        end else if (taken.size() == 0) begin
          expected_words.insert(expected_words.size(), w);
        end else begin
          if (taken.size() > longest_pull) longest_pull = taken.size();
          foreach (taken[i]) begin
            w.has_packet = 1'b1;
            w.out_handle = taken[i];
            w.last = (i == taken.size() - 1);
            expected_words.insert(expected_words.size(), w);
          end
        end
      end
      default: begin
        w.occupancy = COUNT_W'(held_entries.size());
        expected_words.insert(expected_words.size(), w);
      end
    endcase
  endfunction

  function automatic void report_word(input string what, input out_item_t want,
                                      input out_item_t got);
    error_count++;
    if (error_count <= 10)
      $display("%0t: %s: want has=%0b ev=%0b h=%h rm=%0d occ=%0d last=%0b",
               $time, what, want.has_packet, want.evicted, want.out_handle,
               want.removed_count, want.occupancy, want.last,
               "\n    got has=%0b ev=%0b h=%h rm=%0d occ=%0d last=%0b",
               got.has_packet, got.evicted, got.out_handle, got.removed_count,
               got.occupancy, got.last);
  endfunction

  // result checker: every strobed word against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      word_count++;
      if (expected_words.size() == 0) begin
        report_word("word with nothing expected", '0, out_item);
      end else begin
        want_word = expected_words.pop_front();
        if (out_item.has_packet !== want_word.has_packet ||
            out_item.evicted !== want_word.evicted ||
            out_item.out_handle !== want_word.out_handle ||
            out_item.removed_count !== want_word.removed_count ||
            out_item.occupancy !== want_word.occupancy ||
            out_item.last !== want_word.last)
          report_word("mismatch", want_word, out_item);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycle_count,
               expected_words.size());
      $display("dest_keyed_send_buffer_unit_tb: done, errors");
      $finish;
    end
  end

  // start stays high straight into the next command when no gap is drawn
  task automatic send_item(input in_item_t it);
    int unsigned gap;
    gap = no_gap_run ? 0 : $urandom_range(0, 19);
    if ($urandom_range(0, 24) == 0) no_gap_run = !no_gap_run;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    buffer_step(it);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    do @(posedge clk); while (busy);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [COUNT_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 3'(REG_CAPACITY) << 2;
    pwdata <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    capacity_reg = value;
  endtask

  task automatic test_basic_ops();
    send_item(mk(KIND_PUSH, 32'h0000_0000, 16'h0000));
    send_item(mk(KIND_PUSH, 32'hFFFF_FFFF, 16'hFFFF));
    send_item(mk(KIND_PUSH, 32'hC0A8_0001, 16'h1234));
    send_item(mk(KIND_PUSH, 32'h0000_0000, 16'h5555));
    send_item(mk(KIND_PUSH, 32'hC0A8_0001, 16'h00FF));
    send_item(mk(KIND_PULL, 32'hC0A8_0001, 16'hAAAA));
    send_item(mk(KIND_PULL, 32'h1234_5678, 16'h0000));
    send_item(mk(KIND_DROP, 32'h0000_0000, 16'hFFFF));
    send_item(mk(KIND_SPARE, 32'hFFFF_FFFF, 16'hFFFF));
    send_item(mk(KIND_PULL, 32'hFFFF_FFFF, 16'h0000));
    send_item(mk(KIND_PULL, 32'h0000_0000, 16'h0000));
    send_item(mk(KIND_DROP, 32'h0000_0000, 16'h0000));
  endtask

  // smallest setting, zero read as one
  task automatic test_capacity_limits();
    wait_idle();
    write_capacity(6'd1);
    send_item(mk(KIND_PUSH, 32'h0A00_0001, 16'h0101));
    send_item(mk(KIND_PUSH, 32'h0A00_0002, 16'h0202));
    send_item(mk(KIND_PUSH, 32'h0A00_0003, 16'h0303));
    wait_idle();
    write_capacity(6'd0);
    send_item(mk(KIND_PUSH, 32'h0A00_0004, 16'h0404));
    send_item(mk(KIND_PUSH, 32'h0A00_0005, 16'h0505));
  endtask

  // capacity dropped under the fill: pushes evict one each, fill holds
  task automatic test_capacity_shrink();
    wait_idle();
    write_capacity(6'd32);
    for (int i = 0; i < 5; i++) send_item(mk(KIND_PUSH, 32'hAC10_0007, 16'($urandom)));
    wait_idle();
    write_capacity(6'd3);
    send_item(mk(KIND_PUSH, 32'hAC10_0008, 16'($urandom)));
    send_item(mk(KIND_PUSH, 32'hAC10_0008, 16'($urandom)));
    send_item(mk(KIND_DROP, 32'hAC10_0007, 16'($urandom)));
  endtask

  // push past depth on one key (the fill holds at DEPTH), then pull the lot in one command
  task automatic test_full_sweep();
    logic [31:0] key;
    key = $urandom;
    wait_idle();
    write_capacity(6'd63);
    for (int i = 0; i < 36; i++) send_item(mk(KIND_PUSH, key, 16'($urandom)));
    send_item(mk(KIND_PULL, key, 16'($urandom)));
  endtask

  task automatic test_random_phase(input logic [COUNT_W-1:0] cap, input int unsigned n);
    int unsigned r;
    logic [KIND_BITS-1:0] k;
    logic [31:0] a;
    wait_idle();
    write_capacity(cap);
    addr_pool[0] = $urandom;
    addr_pool[1] = $urandom;
    addr_pool[2] = $urandom_range(0, 1) ? 32'h0000_0000 : 32'hFFFF_FFFF;
    addr_pool[3] = $urandom;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      k = (r < 50) ? KIND_PUSH : (r < 75) ? KIND_PULL : (r < 93) ? KIND_DROP : KIND_SPARE;
      a = ($urandom_range(0, 9) == 0) ? $urandom : addr_pool[$urandom_range(0, 3)];
      send_item(mk(k, a, 16'($urandom_range(0, 65535))));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_basic_ops();
    test_capacity_limits();
    test_capacity_shrink();
    test_full_sweep();
    test_random_phase(6'd32, 55);
    test_random_phase(6'd4, 55);
    test_random_phase(6'd0, 50);
    test_random_phase(6'd1, 50);
    test_random_phase(6'd63, 55);
    test_random_phase(6'($urandom_range(2, 31)), 55);
    test_random_phase(6'($urandom_range(33, 62)), 55);
    wait_idle();
    $display("covered %0d push, %0d pull, %0d drop, %0d spare-code commands; %0d words",
             kind_count[0], kind_count[1], kind_count[2], kind_count[3], word_count);
    $display("%0d evictions, capacity 0 to 63, longest pull %0d words", evict_count,
             longest_pull);
    if (error_count == 0 && expected_words.size() == 0) begin
      $display("dest_keyed_send_buffer_unit_tb: done, clean");
    end else begin
      $display("dest_keyed_send_buffer_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
